>>> rtl/core/assert_macros.svh
// shared assertion macros, sampled on clk with synchronous active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/ffra_pkg.sv
package ffra_pkg;

  localparam int FIELD_W = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] STAT_FROM_HOLE = 3'd0;
  localparam logic [2:0] STAT_FROM_BUMP = 3'd1;
  localparam logic [2:0] STAT_FREED     = 3'd2;
  localparam logic [2:0] STAT_DROPPED   = 3'd3;
  localparam logic [2:0] STAT_FAILED    = 3'd4;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] req_size;
    logic [FIELD_W-1:0] free_start;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] alloc_start;
    logic [2:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_RESP
  } state_t;

endpackage

>>> rtl/core/ffra_hole_mem.sv
module ffra_hole_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/ffra_ctrl.sv
module ffra_ctrl #(
  parameter int FREE_SLOTS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffra_pkg::in_item_t  in_data,
  output logic                res_valid,
  output ffra_pkg::out_item_t res,
  input  logic                res_take,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  import ffra_pkg::*;

  `include "assert_macros.svh"

  localparam int IB = INDEX_BITS;
  localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW = $clog2(FREE_SLOTS + 1);

  typedef logic [IB-1:0] idx_t;
  typedef logic [IB:0]   bump_t;
  typedef logic [IB+1:0] sum_t;

  localparam bump_t TOP      = {1'b1, {IB{1'b0}}};
  localparam bump_t BUMP_RST = (INDEX_BITS > 8) ? bump_t'(256) : TOP;

  function automatic idx_t to_idx(input logic [FIELD_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[IB-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input idx_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[FIELD_W-1:0];
  endfunction

  state_t          state_r, state_nxt;
  idx_t            size_r, size_nxt;
  logic [AW-1:0]   scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]   hit_idx_r, hit_idx_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  bump_t           bump_r, bump_nxt;
  out_item_t       res_r, res_nxt;

  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  logic [2*IB-1:0] mem_rd_data;
  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  logic [2*IB-1:0] mem_wr_data;

  logic            in_fire;
  idx_t            in_size;
  idx_t            in_fstart;
  idx_t            rd_start;
  idx_t            rd_len;
  idx_t            new_start;
  idx_t            new_len;
  logic            hit;
  logic [CW-1:0]   count_dec;
  logic [AW-1:0]   last_idx;
  logic            at_last;
  logic            list_full;
  idx_t            bump_size;
  sum_t            bump_sum;
  logic            bump_fail;
  logic [32:0]     cfg_w;

  ffra_hole_mem #(
    .DEPTH (FREE_SLOTS),
    .AW    (AW),
    .DW    (2 * IB)
  ) u_hole_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign in_fire   = in_valid && in_ready;
  assign in_size   = to_idx(in_data.req_size);
  assign in_fstart = to_idx(in_data.free_start);
  assign rd_start  = mem_rd_data[2*IB-1:IB];
  assign rd_len    = mem_rd_data[IB-1:0];
  assign new_start = rd_start + size_r;
  assign new_len   = rd_len - size_r;
  assign hit       = (rd_len >= size_r);
  assign count_dec = count_r - 1'b1;
  assign last_idx  = count_dec[AW-1:0];
  assign at_last   = (scan_idx_r == last_idx);
  assign list_full = (count_r == CW'(FREE_SLOTS));
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  // bump decision uses the incoming size when the list is empty at accept
  assign bump_size = (state_r == S_IDLE) ? in_size : size_r;
  assign bump_sum  = sum_t'(bump_r) + sum_t'(bump_size);
  assign bump_fail = (bump_r == TOP) || (bump_sum > sum_t'(TOP));
  assign cfg_w     = 33'(cfg_wdata);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.cmd == CMD_ALLOC && count_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (new_len == '0 && !at_last) begin
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (at_last) begin
          state_nxt = S_RESP;
        end
      end
      S_MOVE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = (state_r == S_IDLE);
    size_nxt     = size_r;
    scan_idx_nxt = scan_idx_r;
    hit_idx_nxt  = hit_idx_r;
    count_nxt    = count_r;
    bump_nxt     = bump_r;
    res_nxt      = res_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = '0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = '0;
    mem_wr_data  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          size_nxt = in_size;
          if (in_data.cmd == CMD_FREE) begin
            if (list_full) begin
              res_nxt = '{alloc_start: '0, status: STAT_DROPPED};
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = count_r[AW-1:0];
              mem_wr_data = {in_fstart, in_size};
              count_nxt   = count_r + 1'b1;
              res_nxt     = '{alloc_start: '0, status: STAT_FREED};
            end
          end else if (count_r != '0) begin
            mem_rd_en    = 1'b1;
            mem_rd_addr  = '0;
            scan_idx_nxt = '0;
          end else if (bump_fail) begin
            res_nxt = '{alloc_start: '0, status: STAT_FAILED};
          end else begin
            res_nxt  = '{alloc_start: to_field(bump_r[IB-1:0]), status: STAT_FROM_BUMP};
            bump_nxt = bump_sum[IB:0];
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_nxt = '{alloc_start: to_field(rd_start), status: STAT_FROM_HOLE};
          if (new_len != '0) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = scan_idx_r;
            mem_wr_data = {new_start, new_len};
          end else if (at_last) begin
            count_nxt = count_dec;
          end else begin
            // emptied hole: fetch the last entry to swap into its slot
            mem_rd_en   = 1'b1;
            mem_rd_addr = last_idx;
            hit_idx_nxt = scan_idx_r;
          end
        end else if (at_last) begin
          if (bump_fail) begin
            res_nxt = '{alloc_start: '0, status: STAT_FAILED};
          end else begin
            res_nxt  = '{alloc_start: to_field(bump_r[IB-1:0]), status: STAT_FROM_BUMP};
            bump_nxt = bump_sum[IB:0];
          end
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = scan_idx_r + 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_MOVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = hit_idx_r;
        mem_wr_data = mem_rd_data;
        count_nxt   = count_dec;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      bump_nxt = (cfg_w > 33'(TOP)) ? TOP : cfg_w[IB:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      bump_r  <= BUMP_RST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bump_r  <= bump_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    scan_idx_r <= scan_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    res_r      <= res_nxt;
  end

  `ASSERT_ALWAYS(a_count_cap, count_r <= CW'(FREE_SLOTS), "hole count over capacity")
  `ASSERT_ALWAYS(a_bump_cap, bump_r <= TOP, "bump pointer beyond top of space")
  `ASSERT_IMPLY(a_move_after_hit, state_r == S_MOVE, $past(state_r) == S_SCAN, "swap without a hit")
  `ASSERT_IMPLY(a_scan_nonempty, state_r == S_SCAN, count_r != '0, "scan over empty hole list")

endmodule

>>> rtl/core/first_fit_range_allocator.sv
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_ready    | in_data   (cmd, req_size, free_start)
// out_    | output    | out_valid / out_ready  | out_data  (alloc_start, status)
// cfg_    | input     | cfg_we, no wait        | cfg_wdata (start_offset)
//
// a free goes from its transfer to the ctrl result register, then into the output register;
// an allocate also reads holes one per cycle through the single read port of the hole memory
// (at most FREE_SLOTS), and passes a move state when the last entry moves into an emptied hole
// a new item is taken only once the result of the last one has moved into the output register
// reset clears the hole count and loads the bump pointer, no clearing pass
// a stalled result waits in the output register while one more item is worked on
module first_fit_range_allocator #(
  parameter int FREE_SLOTS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffra_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffra_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  import ffra_pkg::*;

  logic      res_valid;
  out_item_t res;
  logic      res_take;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // scan engine with the hole memory, bump pointer and hole count
  ffra_ctrl #(
    .FREE_SLOTS (FREE_SLOTS),
    .INDEX_BITS (INDEX_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // output register: a finished result moves in when the slot is empty or draining
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      // transfer completes with nothing behind it
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sim/first_fit_range_allocator_tb.sv
module first_fit_range_allocator_tb;
  import ffra_pkg::*;

  localparam int FREE_SLOTS = 16;
  localparam int INDEX_BITS = 16;
  localparam logic [16:0] SPACE_TOP = 17'h1_0000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 280;
  localparam int HOLD_AT = 900;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] cfg_val;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } row_t;

  typedef struct {
    logic [15:0] base;
    logic [15:0] len;
  } range_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // own copy of the allocator state
  logic [15:0] hole_base [FREE_SLOTS];
  logic [15:0] hole_len [FREE_SLOTS];
  int          holes = 0;
  logic [16:0] bump = 17'h0_0100;

  out_item_t pending_grants [$];
  range_t    live_ranges [$];
  int        requests_sent = 0;
  int        errors = 0;
  int        cycles = 0;
  int        stall_left = 0;
  bit        hold_done = 1'b0;
  bit        no_gaps = 1'b0;

  first_fit_range_allocator #(
    .FREE_SLOTS(FREE_SLOTS),
    .INDEX_BITS(INDEX_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // works out the grant for one request and updates the hole list and bump pointer
  function automatic out_item_t grant_for(in_item_t it);
    out_item_t   g;
    int          slot;
    logic [16:0] new_top;
    g.alloc_start = '0;
    slot = -1;
    if (it.cmd == CMD_FREE) begin
      if (holes >= FREE_SLOTS) begin
        g.status = STAT_DROPPED;
      end else begin
        hole_base[holes] = it.free_start;
        hole_len[holes] = it.req_size;
        holes++;
        g.status = STAT_FREED;
      end
    end else begin
      // first fit, in list order
      for (int i = 0; i < holes; i++) begin
        if (slot < 0 && hole_len[i] >= it.req_size) slot = i;
      end
      if (slot >= 0) begin
        g.alloc_start = hole_base[slot];
        hole_base[slot] = hole_base[slot] + it.req_size;
        hole_len[slot] = hole_len[slot] - it.req_size;
        // emptied hole: last entry takes its slot
        if (hole_len[slot] == '0) begin
          hole_base[slot] = hole_base[holes-1];
          hole_len[slot] = hole_len[holes-1];
          holes--;
        end
        g.status = STAT_FROM_HOLE;
      end else begin
        new_top = bump + {1'b0, it.req_size};
        if (bump >= SPACE_TOP || new_top > SPACE_TOP) begin
          g.status = STAT_FAILED;
        end else begin
          g.alloc_start = bump[15:0];
          bump = new_top;
          g.status = STAT_FROM_BUMP;
        end
      end
    end
    return g;
  endfunction

  // allocates at alloc_pct percent, frees of ranges handed out earlier, the rest noise frees
  function automatic in_item_t random_request(int alloc_pct);
    in_item_t it;
    int       pick;
    int       k;
    range_t   r;
    it.cmd = CMD_ALLOC;
    it.req_size = 16'($urandom);
    it.free_start = 16'($urandom);
    pick = $urandom_range(99);
    k = $urandom_range(99);
    if (pick < alloc_pct) begin
      if (k < 10) it.req_size = '0;
      else if (k < 75) it.req_size = 16'($urandom_range(64, 1));
      else if (k < 90) it.req_size = 16'($urandom_range(4096, 65));
      else if (k >= 97) it.req_size = 16'hFFFF;
    end else if (pick < 85 && live_ranges.size() != 0) begin
      k = $urandom_range(live_ranges.size() - 1);
      r = live_ranges[k];
      live_ranges.delete(k);
      it.cmd = CMD_FREE;
      it.req_size = r.len;
      it.free_start = r.base;
    end else begin
      it.cmd = CMD_FREE;
      if (k < 75) it.req_size = 16'($urandom_range(64));
    end
    return it;
  endfunction

  // offers one request, holds it until the transfer, then books the expected grant
  task automatic send_request(in_item_t it, bit typed, out_item_t want);
    out_item_t g;
    if (!no_gaps && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = grant_for(it);
    pending_grants.push_back(typed ? want : g);
    if (it.cmd == CMD_ALLOC && it.req_size != '0 &&
        (g.status == STAT_FROM_HOLE || g.status == STAT_FROM_BUMP)) begin
      live_ranges.push_back('{g.alloc_start, it.req_size});
      if (live_ranges.size() > 64) void'(live_ranges.pop_front());
    end
    requests_sent++;
  endtask

  // register write only once the block has drained
  task automatic set_start_offset(logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bump = {1'b0, v};
  endtask

  // result side: random stalls, one long hold-off so the block backs up
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && requests_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= 25);
    end
  end

  // each result transfer against the oldest expected grant
  always @(posedge clk) begin : check_grant
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: alloc_start %h status %0d",
                   out_data.alloc_start, out_data.status);
        end
      end else begin
        want = pending_grants.pop_front();
        if (out_data.alloc_start !== want.alloc_start || out_data.status !== want.status) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: alloc_start exp %h got %h, status exp %0d got %0d",
                     want.alloc_start, out_data.alloc_start, want.status, out_data.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    row_t        plan [30];
    logic [15:0] offset;
    int          alloc_pct;
    plan = '{
      // empty list: zero-size allocate hands out the bump pointer without moving it
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'h0000, 16'hFFFF}, 1'b1, '{16'h0100, STAT_FROM_BUMP}},
      // hole at the very top, its start wraps past the end of the space
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0002, 16'hFFFF}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'h0001, 16'h0000}, 1'b1, '{16'hFFFF, STAT_FROM_HOLE}},
      // zero-length hole
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0000, 16'h1234}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, STAT_FROM_HOLE}},
      // first hole emptied, last one moves into its slot
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'h0001, 16'h0000}, 1'b1, '{16'h0000, STAT_FROM_HOLE}},
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'h0000, 16'h0000}, 1'b1, '{16'h1234, STAT_FROM_HOLE}},
      // past the top of the space
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'hFFFF, 16'h0000}, 1'b1, '{16'h0000, STAT_FAILED}},
      '{ROW_CFG,  16'hFFFF, '{CMD_ALLOC, 16'h0000, 16'h0000}, 1'b0, '0},
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'h0001, 16'h0000}, 1'b1, '{16'hFFFF, STAT_FROM_BUMP}},
      // bump pointer sitting at the top
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, STAT_FAILED}},
      '{ROW_CFG,  16'h0000, '{CMD_ALLOC, 16'h0000, 16'h0000}, 1'b0, '0},
      '{ROW_ITEM, 16'h0000, '{CMD_ALLOC, 16'hFFFF, 16'h0000}, 1'b1, '{16'h0000, STAT_FROM_BUMP}},
      // fill the hole list
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0001, 16'h0000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0008, 16'h0010}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0010, 16'h0100}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0020, 16'h0200}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0004, 16'h0400}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0002, 16'h0800}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0040, 16'h1000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0003, 16'h2000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0005, 16'h4000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0006, 16'h8000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0007, 16'hA000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0100, 16'hC000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0009, 16'hE000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h0000, 16'hF000}, 1'b1, '{16'h0000, STAT_FREED}},
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'h8000, 16'h7FFF}, 1'b1, '{16'h0000, STAT_FREED}},
      // full list drops the free
      '{ROW_ITEM, 16'h0000, '{CMD_FREE,  16'hAAAA, 16'h5555}, 1'b1, '{16'h0000, STAT_DROPPED}}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_start_offset(plan[i].cfg_val);
      else send_request(plan[i].item, plan[i].typed, plan[i].want);
    end

    // random phases, each from its own start offset; phase two runs without gaps
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: offset = 16'($urandom_range(4095));
        1: offset = 16'hFFFF;
        2: offset = 16'($urandom);
        3: offset = 16'h0000;
        4: offset = 16'hFFF0;
        default: offset = 16'($urandom_range(4095));
      endcase
      alloc_pct = (p % 2 == 1) ? 65 : 40;
      set_start_offset(offset);
      no_gaps = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(alloc_pct), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
